// File: rtl/dsrsp_pkg.sv
// Shared types and constants for the dense swap-remove slot pool.
package dsrsp_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OBJ_W      = 8;
    localparam int CAP_W      = 9;

    // object_to_position entry for an object that is not in use
    localparam logic [CNT_W-1:0] POS_INVALID = '1;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] object_id;
        logic [7:0] position_index;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] result_object;
        logic [7:0] result_position;
        logic [8:0] in_use_count;
    } result_t;

    typedef struct packed {
        logic accept;
        logic alloc_wr;
        logic free_move;
        logic free_park;
        logic respond;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       alloc_ok;
        logic       free_ok;
    } dp_stat_t;

endpackage

// File: rtl/dsrsp_ctrl.sv
// Sequencer for the slot pool: accept, execute and swap-park steps.
module dsrsp_ctrl
    import dsrsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PARK
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.opcode == OP_FREE && stat.free_ok)
                begin
                    // first half of the swap, second half parks the freed object
                    cmd.free_move = 1'b1;
                    state_next    = S_PARK;
                end
                else
                begin
                    cmd.alloc_wr = (stat.opcode == OP_ALLOC) && stat.alloc_ok;
                    cmd.respond  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PARK:
            begin
                cmd.free_park = 1'b1;
                cmd.respond   = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/dsrsp_datapath.sv
// Position and inverse maps, in-use count, capacity register and result register.
module dsrsp_datapath
    import dsrsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            item,
    input  logic             cfg_valid,
    input  logic [CAP_W-1:0] cfg_data,
    input  ctrl_cmd_t        cmd,
    output dp_stat_t         stat,
    output result_t          result,
    output logic             done
);

    logic [OBJ_W-1:0] p2o_mem [POOL_DEPTH];
    logic [CNT_W-1:0] o2p_mem [POOL_DEPTH];
    // positions and objects below this mark have been written in both maps
    logic [CNT_W-1:0] hwm_reg;

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;

    logic [1:0]       op_reg;
    logic [OBJ_W-1:0] obj_reg;
    logic [IDX_W-1:0] pos_reg;
    logic             full_reg;
    logic             range_bad_reg;

    // registered read ports
    logic [OBJ_W-1:0] p2o_q_reg;
    logic             p2o_hit_reg;
    logic [IDX_W-1:0] p2o_addr_reg;
    logic [CNT_W-1:0] o2p_q_reg;
    logic             o2p_hit_reg;

    logic [OBJ_W-1:0] p2o_rd;
    logic [CNT_W-1:0] o2p_rd;

    logic [CAP_W-1:0] cap_eff;
    logic [IDX_W-1:0] p2o_raddr;
    logic [IDX_W-1:0] last_idx;

    logic             p2o_we;
    logic [IDX_W-1:0] p2o_waddr;
    logic [OBJ_W-1:0] p2o_wdata;
    logic             o2p_we;
    logic [IDX_W-1:0] o2p_waddr;
    logic [CNT_W-1:0] o2p_wdata;

    result_t          result_next;

    result_t          result_reg;
    logic             done_reg;

    assign cap_eff  = (cap_reg > CAP_W'(POOL_DEPTH)) ? CAP_W'(POOL_DEPTH) : cap_reg;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // never-written entries read as their reset values
    assign p2o_rd = p2o_hit_reg ? p2o_q_reg : OBJ_W'(p2o_addr_reg);
    assign o2p_rd = o2p_hit_reg ? o2p_q_reg : POS_INVALID;

    always_comb
    begin
        case (item.opcode)
            OP_ALLOC: p2o_raddr = count_reg[IDX_W-1:0];
            OP_FREE:  p2o_raddr = last_idx;
            default:  p2o_raddr = item.position_index[IDX_W-1:0];
        endcase
    end

    assign stat.opcode   = op_reg;
    assign stat.alloc_ok = !full_reg;
    assign stat.free_ok  = (count_reg != '0) && (o2p_rd != POS_INVALID)
                           && (o2p_rd < count_reg);

    // write port selection; allocate rewrites its own position to advance the mark
    always_comb
    begin
        p2o_we    = cmd.alloc_wr || cmd.free_move || cmd.free_park;
        p2o_wdata = cmd.free_park ? obj_reg : p2o_rd;
        o2p_we    = cmd.alloc_wr || cmd.free_move || cmd.free_park;
        if (cmd.free_park)
        begin
            p2o_waddr = last_idx;
            o2p_waddr = obj_reg[IDX_W-1:0];
            o2p_wdata = POS_INVALID;
        end
        else if (cmd.free_move)
        begin
            p2o_waddr = o2p_rd[IDX_W-1:0];
            o2p_waddr = p2o_rd[IDX_W-1:0];
            o2p_wdata = o2p_rd;
        end
        else
        begin
            p2o_waddr = count_reg[IDX_W-1:0];
            o2p_waddr = p2o_rd[IDX_W-1:0];
            o2p_wdata = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p2o_q_reg    <= p2o_mem[p2o_raddr];
            p2o_addr_reg <= p2o_raddr;
            o2p_q_reg    <= o2p_mem[item.object_id[IDX_W-1:0]];
        end
        if (p2o_we)
            p2o_mem[p2o_waddr] <= p2o_wdata;
        if (o2p_we)
            o2p_mem[o2p_waddr] <= o2p_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hwm_reg     <= '0;
            p2o_hit_reg <= 1'b0;
            o2p_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                p2o_hit_reg <= (CNT_W'(p2o_raddr) < hwm_reg);
                o2p_hit_reg <= (CNT_W'(item.object_id[IDX_W-1:0]) < hwm_reg);
            end
            if (cmd.alloc_wr && (count_reg == hwm_reg))
                hwm_reg <= hwm_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg        <= item.opcode;
            obj_reg       <= item.object_id;
            pos_reg       <= item.position_index[IDX_W-1:0];
            full_reg      <= (CAP_W'(count_reg) >= cap_eff);
            range_bad_reg <= (CAP_W'(item.position_index) >= cap_eff);
        end
    end

    always_comb
    begin
        result_next = '{status: ST_BAD, result_object: '0, result_position: '0,
                        in_use_count: count_reg};
        case (op_reg)
            OP_ALLOC:
            begin
                if (full_reg)
                    result_next.status = ST_FULL;
                else
                begin
                    result_next.status          = ST_OK;
                    result_next.result_object   = p2o_rd;
                    result_next.result_position = count_reg[IDX_W-1:0];
                    result_next.in_use_count    = count_reg + CNT_W'(1);
                end
            end
            OP_FREE:
            begin
                if (count_reg == '0)
                    result_next.status = ST_EMPTY;
                else if (cmd.free_park)
                begin
                    result_next.status          = ST_OK;
                    result_next.result_object   = obj_reg;
                    result_next.result_position = o2p_rd[IDX_W-1:0];
                    result_next.in_use_count    = count_reg - CNT_W'(1);
                end
            end
            OP_LOOKUP:
            begin
                if (!range_bad_reg)
                begin
                    result_next.status          = ST_OK;
                    result_next.result_object   = p2o_rd;
                    result_next.result_position = pos_reg;
                end
            end
            default:
            begin
                result_next.status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_W'(256);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (cmd.alloc_wr)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.free_park)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
            result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// File: rtl/dense_swap_remove_slot_pool.sv
// Dense slot pool with swap-with-last free: top level.
// Allocate, lookup and any error answer from the execute state; a good free, from the park state.
// A new item is accepted only back in idle, after the registered map read and execute;
//   a good free also needs the park state, since the swap needs two writes to the position table.
// done pulses one cycle with result; the receiver cannot stall.
// Reset: count 0, capacity 256; map entries at or above a written-high mark read as reset values.
module dense_swap_remove_slot_pool
    import dsrsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    dsrsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    dsrsp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result),
        .done      (done)
    );

endmodule
